@@ rtl/core/stpg_pkg.sv @@
// shared constants, opcodes and control structs for the step pulse generator
package stpg_pkg;

	localparam int NUM_AXES   = 3;
	localparam int OUT_AXES   = 3;
	localparam int STEP_BITS  = 16;
	localparam int TIMER_BITS = 32;
	localparam int TOGGLE_W   = STEP_BITS + 1;
	localparam int HALF_W     = TIMER_BITS - 1;

	localparam logic [OUT_AXES-1:0] LIMIT_MASK = OUT_AXES'((1 << NUM_AXES) - 1);

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_LOAD  = 2'd1,
		OP_ABORT = 2'd2,
		OP_CLEAR = 2'd3
	} stpg_op_t;

	// per-axis command, already qualified by the stage advance
	typedef struct packed {
		logic tick;      // tick with no limit raised
		logic start_ok;  // no axis is moving
		logic stop;      // limit tick or abort
		logic load;      // load command for this axis
	} stpg_axis_cmd_t;

	typedef struct packed {
		logic pulse;
		logic dir;
		logic moving;
		logic pend;
	} stpg_axis_stat_t;

endpackage

@@ rtl/core/stpg_axis.sv @@
// one axis: pending move, step timing, pulse and direction pins, captured count
module stpg_axis
	import stpg_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  stpg_axis_cmd_t        cmd,
	input  logic [STEP_BITS-1:0]  load_steps,
	input  logic [TIMER_BITS-1:0] load_length,
	input  logic                  load_dir,
	output stpg_axis_stat_t       stat,
	output logic [TOGGLE_W-1:0]   captured
);

	// posted move, payload only
	logic [STEP_BITS-1:0]  psteps_q;
	logic [TIMER_BITS-1:0] plen_q;
	logic                  pdir_q;

	logic                  pend_q, pend_d;
	logic                  moving_q, moving_d;
	logic                  pulse_q, pulse_d;
	logic                  dir_q, dir_d;
	logic [TOGGLE_W-1:0]   toggle_q, toggle_d;
	logic [TOGGLE_W-1:0]   target_q, target_d;
	logic [HALF_W-1:0]     half_q, half_d;
	logic [TIMER_BITS-1:0] elapsed_q, elapsed_d;
	logic [TOGGLE_W-1:0]   cap_q, cap_d;

	logic [TIMER_BITS-1:0] elapsed_inc;
	logic [TOGGLE_W-1:0]   toggle_inc;
	logic                  fire;

	assign elapsed_inc = (elapsed_q != '1) ? elapsed_q + TIMER_BITS'(1) : elapsed_q;
	assign toggle_inc  = toggle_q + TOGGLE_W'(1);
	assign fire        = elapsed_inc >= {1'b0, half_q};

	always_comb begin
		pend_d    = pend_q;
		moving_d  = moving_q;
		pulse_d   = pulse_q;
		dir_d     = dir_q;
		toggle_d  = toggle_q;
		target_d  = target_q;
		half_d    = half_q;
		elapsed_d = elapsed_q;
		cap_d     = cap_q;
		if (cmd.stop) begin
			cap_d     = toggle_q;
			toggle_d  = '0;
			moving_d  = 1'b0;
			pulse_d   = 1'b0;
			elapsed_d = '0;
			pend_d    = 1'b0;
		end else if (cmd.load) begin
			pend_d = 1'b1;
		end else if (cmd.tick) begin
			if (cmd.start_ok && pend_q) begin
				// start and make the first toggle on the same tick
				pend_d    = 1'b0;
				dir_d     = pdir_q;
				half_d    = plen_q[TIMER_BITS-1:1];
				target_d  = {psteps_q, 1'b0};
				elapsed_d = '0;
				toggle_d  = '0;
				pulse_d   = 1'b0;
				moving_d  = 1'b0;
				if (psteps_q != '0) begin
					moving_d = 1'b1;
					pulse_d  = 1'b1;
					toggle_d = TOGGLE_W'(1);
				end
			end else if (moving_q) begin
				elapsed_d = elapsed_inc;
				if (fire) begin
					pulse_d   = !pulse_q;
					elapsed_d = '0;
					toggle_d  = toggle_inc;
					if (toggle_inc == target_q) begin
						toggle_d = '0;
						moving_d = 1'b0;
						pulse_d  = 1'b0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q    <= 1'b0;
			moving_q  <= 1'b0;
			pulse_q   <= 1'b0;
			dir_q     <= 1'b0;
			toggle_q  <= '0;
			target_q  <= '0;
			half_q    <= '0;
			elapsed_q <= '0;
			cap_q     <= '0;
		end else begin
			pend_q    <= pend_d;
			moving_q  <= moving_d;
			pulse_q   <= pulse_d;
			dir_q     <= dir_d;
			toggle_q  <= toggle_d;
			target_q  <= target_d;
			half_q    <= half_d;
			elapsed_q <= elapsed_d;
			cap_q     <= cap_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			psteps_q <= load_steps;
			plen_q   <= load_length;
			pdir_q   <= load_dir;
		end
	end

	assign stat.pulse  = pulse_q;
	assign stat.dir    = dir_q;
	assign stat.moving = moving_q;
	assign stat.pend   = pend_q;
	assign captured    = cap_q;

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!moving_q |-> (!pulse_q && toggle_q == '0))
		else $error("idle axis with pulse high or nonzero toggle count");

	a_count_below_target: assert property (@(posedge clk) disable iff (!arst_n)
		moving_q |-> (target_q != '0 && toggle_q < target_q))
		else $error("moving axis toggle count not below target");

	a_stop_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.stop |=> (!moving_q && !pend_q && !pulse_q))
		else $error("axis still active after stop");

endmodule

@@ rtl/core/three_axis_step_pulse_generator_core.sv @@
// top level of the three-axis step pulse generator: input stage, command decode, axes
//
// usage
//  - input channel (in_valid / in_stall) carries one command per transfer: a tick, a
//    move load for one axis, an abort, or a limit flag clear; limit_inputs count only
//    on a tick
//  - output channel (out_valid / out_stall) returns one status transfer per command:
//    pin levels, busy and pending bits, sticky limit flags and captured toggle counts,
//    all as they stand after that command
//  - from input transfer to output valid, a command passes the input register, then the
//    axis state and status registers, which update together
//  - throughput is one command per cycle without stalls; the input register and the
//    status registers form two stages, so a new command is taken while a result waits
//  - the rate is set by the single pass through the axis update logic, a 32-bit
//    increment and compare per axis
//  - when the receiver stalls, the status holds and the axis state does not move;
//    one more command waits in the input register, then in_stall rises
//  - reset clears all axis state, flags and captured counts; posted move payloads
//    are undefined until loaded, guarded by the pending bits
module three_axis_step_pulse_generator_core
	import stpg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic [1:0]  axis,
	input  logic [15:0] step_count,
	input  logic [31:0] pulse_length,
	input  logic        direction,
	input  logic [2:0]  limit_inputs,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  pulse_pins,
	output logic [2:0]  direction_pins,
	output logic [2:0]  busy_res,
	output logic [2:0]  pending,
	output logic [2:0]  limit_flags,
	output logic [16:0] captured_count_a,
	output logic [16:0] captured_count_b,
	output logic [16:0] captured_count_c
);

	// input stage
	logic                  valid_s1;
	stpg_op_t              op_s1;
	logic [1:0]            axis_s1;
	logic [STEP_BITS-1:0]  steps_s1;
	logic [TIMER_BITS-1:0] length_s1;
	logic                  dir_s1;
	logic [OUT_AXES-1:0]   limits_s1;

	logic                  out_valid_q;
	logic [OUT_AXES-1:0]   limit_q;

	logic                  advance;
	logic [OUT_AXES-1:0]   limit_hit;
	logic                  tick_run;
	logic                  stop_all;
	logic [NUM_AXES-1:0]   moving;

	stpg_axis_cmd_t        cmd      [NUM_AXES];
	stpg_axis_stat_t       stat     [NUM_AXES];
	logic [TOGGLE_W-1:0]   captured [NUM_AXES];
	logic [TOGGLE_W-1:0]   cap_out  [OUT_AXES];

	// the stage advances when the status slot is free or being taken
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1     <= stpg_op_t'(op);
			axis_s1   <= axis;
			steps_s1  <= step_count[STEP_BITS-1:0];
			length_s1 <= pulse_length[TIMER_BITS-1:0];
			dir_s1    <= direction;
			limits_s1 <= limit_inputs;
		end
	end

	// command decode; a tick with any limit raised stops motion instead of running the axes
	assign limit_hit = limits_s1 & LIMIT_MASK;
	assign tick_run  = advance && op_s1 == OP_TICK && limit_hit == '0;
	assign stop_all  = advance && ((op_s1 == OP_TICK && limit_hit != '0) ||
		op_s1 == OP_ABORT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			limit_q     <= '0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (advance && op_s1 == OP_TICK) begin
				limit_q <= limit_q | limit_hit;
			end else if (advance && op_s1 == OP_CLEAR) begin
				limit_q <= '0;
			end
		end
	end

	// axes
	genvar a;
	generate
		for (a = 0; a < NUM_AXES; a++) begin : g_axis
			assign moving[a]       = stat[a].moving;
			assign cmd[a].tick     = tick_run;
			assign cmd[a].start_ok = moving == '0;
			assign cmd[a].stop     = stop_all;
			assign cmd[a].load     = advance && op_s1 == OP_LOAD && 32'(axis_s1) == a;

			stpg_axis u_axis (
				.clk         (clk),
				.arst_n      (arst_n),
				.cmd         (cmd[a]),
				.load_steps  (steps_s1),
				.load_length (length_s1),
				.load_dir    (dir_s1),
				.stat        (stat[a]),
				.captured    (captured[a])
			);
		end

		// status bits; axes beyond the configured count read zero
		for (a = 0; a < OUT_AXES; a++) begin : g_out
			if (a < NUM_AXES) begin : g_used
				assign pulse_pins[a]     = stat[a].pulse;
				assign direction_pins[a] = stat[a].dir;
				assign busy_res[a]       = stat[a].moving;
				assign pending[a]        = stat[a].pend;
				assign cap_out[a]        = captured[a];
			end else begin : g_unused
				assign pulse_pins[a]     = 1'b0;
				assign direction_pins[a] = 1'b0;
				assign busy_res[a]       = 1'b0;
				assign pending[a]        = 1'b0;
				assign cap_out[a]        = '0;
			end
		end
	endgenerate

	assign out_valid        = out_valid_q;
	assign limit_flags      = limit_q;
	assign captured_count_a = 17'(cap_out[0]);
	assign captured_count_b = 17'(cap_out[1]);
	assign captured_count_c = 17'(cap_out[2]);

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> ($stable(pulse_pins) && $stable(busy_res) &&
		$stable(pending) && $stable(limit_flags)))
		else $error("status changed while the output transfer was stalled");

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("input stalled without a waiting item and a stalled result");

	a_limit_sets_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && op_s1 == OP_TICK && limit_hit != '0) |=>
		((limit_flags & $past(limit_hit)) == $past(limit_hit) && busy_res == '0))
		else $error("limit tick did not set flags or stop motion");

endmodule
